/* rtl/core/mep_pkg.sv */
// Shared types, constants and helpers for the Mandelbrot escape-time pixel engine.
// Fixed-point word layout, saturation, register map and reset values.
// No dependencies.
package mep_pkg;

   // Q4.28 word: four integer bits (sign included) and FRACTION_BITS fraction bits
   localparam int FRACTION_BITS = 28;
   localparam int WORD_BITS     = FRACTION_BITS + 4;
   // magnitude of a product after the fraction shift
   localparam int PROD_BITS     = 2 * WORD_BITS - FRACTION_BITS;
   localparam int SAT_BITS      = 2 * WORD_BITS;

   localparam int PIXEL_BITS_DEFAULT     = 12;
   localparam int ITERATION_BITS_DEFAULT = 10;

   localparam int STEP_BITS    = 31;
   localparam int OFFSET_BITS  = 32;
   localparam int SCALE_BITS   = 24;
   localparam int COLOUR_BITS  = 8;
   localparam int COLOUR_SHIFT = 16;
   localparam logic [COLOUR_BITS-1:0] COLOUR_MAX = 8'd255;

   localparam int QUEUE_DEPTH = 2;

   localparam int CSR_ADDR_BITS  = 5;
   localparam int CSR_DATA_BITS  = 32;
   localparam int CSR_INDEX_BITS = 3;

   localparam logic [CSR_INDEX_BITS-1:0] REG_MAX_ITERATIONS = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_STEP_X         = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] REG_STEP_Y         = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] REG_X_OFFSET       = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] REG_Y_OFFSET       = 3'd4;
   localparam logic [CSR_INDEX_BITS-1:0] REG_COLOR_SCALE    = 3'd5;

   localparam int MAX_ITERATIONS_RESET = 50;
   localparam logic [STEP_BITS-1:0]  STEP_X_RESET      = 31'd1048576;
   localparam logic [STEP_BITS-1:0]  STEP_Y_RESET      = 31'd1398101;
   localparam logic [SCALE_BITS-1:0] COLOR_SCALE_RESET = 24'd334234;

   typedef logic signed [WORD_BITS-1:0] word_type;
   typedef logic signed [SAT_BITS-1:0]  wide_type;

   typedef struct packed {
      word_type cx;
      word_type cy;
   } point_type;

   typedef struct packed {
      logic [STEP_BITS-1:0]          step_x;
      logic [STEP_BITS-1:0]          step_y;
      logic signed [OFFSET_BITS-1:0] x_offset;
      logic signed [OFFSET_BITS-1:0] y_offset;
   } map_cfg_type;

   localparam wide_type WORD_MAX_WIDE =
      wide_type'({{(SAT_BITS - WORD_BITS + 1){1'b0}}, {(WORD_BITS - 1){1'b1}}});
   localparam wide_type WORD_MIN_WIDE = ~WORD_MAX_WIDE;

   // clamp a wide signed value to the word range
   function automatic word_type sat_word(input wide_type v);
      word_type r;
      if (v > WORD_MAX_WIDE) begin
         r = WORD_MAX_WIDE[WORD_BITS-1:0];
      end else if (v < WORD_MIN_WIDE) begin
         r = WORD_MIN_WIDE[WORD_BITS-1:0];
      end else begin
         r = v[WORD_BITS-1:0];
      end
      return r;
   endfunction

endpackage

/* rtl/core/mandelbrot_escape_pixel.sv */
// Top level of the Mandelbrot escape-time pixel engine: register file and channel wiring.
// Uses mep_pkg, mep_front, mep_queue, mep_escape and mep_colour.
//
//   channel   direction  handshake            word
//   req       in         push / full          pixel_x, pixel_y
//   rsp       out        pop / empty          last_test, inside_set, red, green, blue
//   csr       in/out     psel/penable/pready  max_iterations .. color_scale, 4-byte stride
//
// A pixel passes through the front end's pixel and product registers and the queue.
// The escape core then accepts it and runs each test as a multiply step and an add/check
// step, plus a final check. It then hands over to the colour register. The core takes a
// new pixel only once it is back in its idle state.
// Reset is synchronous, clears only control state and loads register reset values.
// A two-point queue parts front and core; the colour register holds a result while the
// core starts the next pixel, so push stalls only when the front end and queue are full.
module mandelbrot_escape_pixel
   import mep_pkg::*;
#(
   parameter int PIXEL_BITS     = PIXEL_BITS_DEFAULT,
   parameter int ITERATION_BITS = ITERATION_BITS_DEFAULT
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         push,
   output logic                         full,
   input  logic signed [PIXEL_BITS-1:0] req_pixel_x,
   input  logic signed [PIXEL_BITS-1:0] req_pixel_y,
   output logic                         empty,
   input  logic                         pop,
   output logic [ITERATION_BITS-1:0]    rsp_last_test,
   output logic                         rsp_inside_set,
   output logic [COLOUR_BITS-1:0]       rsp_red,
   output logic [COLOUR_BITS-1:0]       rsp_green,
   output logic [COLOUR_BITS-2:0]       rsp_blue,
   input  logic                         psel,
   input  logic                         penable,
   input  logic                         pwrite,
   input  logic [CSR_ADDR_BITS-1:0]     paddr,
   input  logic [CSR_DATA_BITS-1:0]     pwdata,
   output logic [CSR_DATA_BITS-1:0]     prdata,
   output logic                         pready
);

   logic [ITERATION_BITS-1:0]     max_iter_ff;
   logic [STEP_BITS-1:0]          step_x_ff, step_y_ff;
   logic signed [OFFSET_BITS-1:0] x_offset_ff, y_offset_ff;
   logic [SCALE_BITS-1:0]         scale_ff;
   logic [CSR_INDEX_BITS-1:0]     reg_index;
   logic                          csr_write;

   map_cfg_type                   map_cfg;
   logic                          front_valid, front_ready;
   point_type                     front_point;
   logic                          queue_valid, queue_ready;
   point_type                     queue_point;
   logic                          esc_valid, esc_ready, esc_inside;
   logic [ITERATION_BITS-1:0]     esc_last;
   logic                          rsp_valid;

   assign pready    = 1'b1;
   assign reg_index = paddr[CSR_ADDR_BITS-1:2];
   assign csr_write = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_iter_ff <= ITERATION_BITS'(MAX_ITERATIONS_RESET);
         step_x_ff   <= STEP_X_RESET;
         step_y_ff   <= STEP_Y_RESET;
         x_offset_ff <= '0;
         y_offset_ff <= '0;
         scale_ff    <= COLOR_SCALE_RESET;
      end else if (csr_write) begin
         case (reg_index)
            REG_MAX_ITERATIONS: max_iter_ff <= pwdata[ITERATION_BITS-1:0];
            REG_STEP_X:         step_x_ff   <= pwdata[STEP_BITS-1:0];
            REG_STEP_Y:         step_y_ff   <= pwdata[STEP_BITS-1:0];
            REG_X_OFFSET:       x_offset_ff <= pwdata[OFFSET_BITS-1:0];
            REG_Y_OFFSET:       y_offset_ff <= pwdata[OFFSET_BITS-1:0];
            REG_COLOR_SCALE:    scale_ff    <= pwdata[SCALE_BITS-1:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (reg_index)
         REG_MAX_ITERATIONS: prdata = CSR_DATA_BITS'(max_iter_ff);
         REG_STEP_X:         prdata = CSR_DATA_BITS'(step_x_ff);
         REG_STEP_Y:         prdata = CSR_DATA_BITS'(step_y_ff);
         REG_X_OFFSET:       prdata = CSR_DATA_BITS'(x_offset_ff);
         REG_Y_OFFSET:       prdata = CSR_DATA_BITS'(y_offset_ff);
         REG_COLOR_SCALE:    prdata = CSR_DATA_BITS'(scale_ff);
         default:            prdata = '0;
      endcase
   end

   assign map_cfg.step_x   = step_x_ff;
   assign map_cfg.step_y   = step_y_ff;
   assign map_cfg.x_offset = x_offset_ff;
   assign map_cfg.y_offset = y_offset_ff;

   mep_front #(
      .PIXEL_BITS (PIXEL_BITS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .full      (full),
      .pixel_x   (req_pixel_x),
      .pixel_y   (req_pixel_y),
      .cfg       (map_cfg),
      .out_valid (front_valid),
      .out_point (front_point),
      .out_ready (front_ready)
   );

   mep_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (front_valid),
      .push_data  (front_point),
      .push_ready (front_ready),
      .pop_valid  (queue_valid),
      .pop_data   (queue_point),
      .pop_ready  (queue_ready)
   );

   mep_escape #(
      .ITERATION_BITS (ITERATION_BITS)
   ) u_escape (
      .clock          (clock),
      .reset          (reset),
      .in_valid       (queue_valid),
      .in_point       (queue_point),
      .in_ready       (queue_ready),
      .max_iterations (max_iter_ff),
      .out_valid      (esc_valid),
      .out_last       (esc_last),
      .out_inside     (esc_inside),
      .out_ready      (esc_ready)
   );

   mep_colour #(
      .ITERATION_BITS (ITERATION_BITS)
   ) u_colour (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (esc_valid),
      .in_last     (esc_last),
      .in_inside   (esc_inside),
      .in_ready    (esc_ready),
      .color_scale (scale_ff),
      .out_valid   (rsp_valid),
      .out_last    (rsp_last_test),
      .out_inside  (rsp_inside_set),
      .out_red     (rsp_red),
      .out_green   (rsp_green),
      .out_blue    (rsp_blue),
      .out_ready   (pop)
   );

   assign empty = !rsp_valid;

endmodule

/* rtl/core/mep_front.sv */
// Front end: takes pixel words and maps them to complex points c = pixel*step + offset.
// Two register stages (pixel, product); depends on mep_pkg.
module mep_front
   import mep_pkg::*;
#(
   parameter int PIXEL_BITS = PIXEL_BITS_DEFAULT
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         push,
   output logic                         full,
   input  logic signed [PIXEL_BITS-1:0] pixel_x,
   input  logic signed [PIXEL_BITS-1:0] pixel_y,
   input  map_cfg_type                  cfg,
   output logic                         out_valid,
   output point_type                    out_point,
   input  logic                         out_ready
);

   localparam int MUL_BITS = PIXEL_BITS + STEP_BITS + 1;

   logic                         a_valid_ff, a_valid_in;
   logic signed [PIXEL_BITS-1:0] px_ff, py_ff;
   logic                         b_valid_ff, b_valid_in;
   logic signed [MUL_BITS-1:0]   prod_x_ff, prod_y_ff, prod_x_in, prod_y_in;
   logic                         a_ready, b_ready;

   assign b_ready = !b_valid_ff || out_ready;
   assign a_ready = !a_valid_ff || b_ready;
   assign full    = !a_ready;

   assign a_valid_in = a_ready ? push : a_valid_ff;
   assign b_valid_in = b_ready ? a_valid_ff : b_valid_ff;

   assign prod_x_in = px_ff * $signed({1'b0, cfg.step_x});
   assign prod_y_in = py_ff * $signed({1'b0, cfg.step_y});

   assign out_valid    = b_valid_ff;
   assign out_point.cx = sat_word(wide_type'(sat_word(wide_type'(prod_x_ff)))
                                  + wide_type'(cfg.x_offset));
   assign out_point.cy = sat_word(wide_type'(sat_word(wide_type'(prod_y_ff)))
                                  + wide_type'(cfg.y_offset));

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= a_valid_in;
         b_valid_ff <= b_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (a_ready && push) begin
         px_ff <= pixel_x;
         py_ff <= pixel_y;
      end
      if (b_ready && a_valid_ff) begin
         prod_x_ff <= prod_x_in;
         prod_y_ff <= prod_y_in;
      end
   end

endmodule

/* rtl/core/mep_queue.sv */
// Short point queue between the mapping front end and the escape core.
// Register-based, QUEUE_DEPTH entries; depends on mep_pkg.
module mep_queue
   import mep_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      push_valid,
   input  point_type push_data,
   output logic      push_ready,
   output logic      pop_valid,
   output point_type pop_data,
   input  logic      pop_ready
);

   localparam int PTR_BITS = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);

   point_type           entries_ff [QUEUE_DEPTH];
   logic [PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_BITS-1:0] count_ff, count_in;
   logic                do_push, do_pop;

   function automatic logic [PTR_BITS-1:0] next_ptr(input logic [PTR_BITS-1:0] p);
      logic [PTR_BITS-1:0] r;
      if (p == PTR_BITS'(QUEUE_DEPTH - 1)) begin
         r = '0;
      end else begin
         r = p + 1'b1;
      end
      return r;
   endfunction

   assign push_ready = count_ff != CNT_BITS'(QUEUE_DEPTH);
   assign pop_valid  = count_ff != '0;
   assign pop_data   = entries_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = do_push ? next_ptr(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = do_pop ? next_ptr(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

/* rtl/core/mep_escape.sv */
// Escape core: iterates z = z^2 + c for one point, each test a multiply step, then an
// add and escape-check step. Depends on mep_pkg.
module mep_escape
   import mep_pkg::*;
#(
   parameter int ITERATION_BITS = ITERATION_BITS_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      in_valid,
   input  point_type                 in_point,
   output logic                      in_ready,
   input  logic [ITERATION_BITS-1:0] max_iterations,
   output logic                      out_valid,
   output logic [ITERATION_BITS-1:0] out_last,
   output logic                      out_inside,
   input  logic                      out_ready
);

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_MUL  = 4'b0010,
      ST_ADD  = 4'b0100,
      ST_DONE = 4'b1000
   } esc_state_type;

   localparam logic [PROD_BITS:0] FOUR_MAG = (PROD_BITS + 1)'(1) << (FRACTION_BITS + 2);

   esc_state_type               state_ff, state_in;
   word_type                    cx_ff, cx_in, cy_ff, cy_in;
   word_type                    zx_ff, zx_in, zy_ff, zy_in;
   logic [PROD_BITS-1:0]        sqx_ff, sqx_in, sqy_ff, sqy_in;
   logic signed [PROD_BITS:0]   xy_ff, xy_in;
   logic [ITERATION_BITS-1:0]   t_ff, t_in, last_ff, last_in;
   logic                        inside_ff, inside_in;

   logic [WORD_BITS-1:0]        abs_x, abs_y;
   logic [2*WORD_BITS-1:0]      full_xx, full_yy, full_xy;
   logic [PROD_BITS-1:0]        mag_xy;
   logic [PROD_BITS:0]          mag;
   logic signed [PROD_BITS:0]   re;
   word_type                    im, zx_new, zy_new;
   logic [ITERATION_BITS-1:0]   limit;
   logic                        escaped, finish;

   // products of the current z, magnitudes only; sign is put back on the cross term
   assign abs_x   = zx_ff[WORD_BITS-1] ? WORD_BITS'(-zx_ff) : WORD_BITS'(zx_ff);
   assign abs_y   = zy_ff[WORD_BITS-1] ? WORD_BITS'(-zy_ff) : WORD_BITS'(zy_ff);
   assign full_xx = abs_x * abs_x;
   assign full_yy = abs_y * abs_y;
   assign full_xy = abs_x * abs_y;
   assign sqx_in  = full_xx[2*WORD_BITS-1:FRACTION_BITS];
   assign sqy_in  = full_yy[2*WORD_BITS-1:FRACTION_BITS];
   assign mag_xy  = full_xy[2*WORD_BITS-1:FRACTION_BITS];
   assign xy_in   = (zx_ff[WORD_BITS-1] ^ zy_ff[WORD_BITS-1]) ?
                    -$signed({1'b0, mag_xy}) : $signed({1'b0, mag_xy});

   // |z|^2 of the current z doubles as the squares of the next test
   assign mag     = {1'b0, sqx_ff} + {1'b0, sqy_ff};
   assign escaped = mag >= FOUR_MAG;
   assign re      = $signed({1'b0, sqx_ff}) - $signed({1'b0, sqy_ff});
   assign im      = sat_word(wide_type'(xy_ff) <<< 1);
   assign zx_new  = sat_word(wide_type'(re) + wide_type'(cx_ff));
   assign zy_new  = sat_word(wide_type'(im) + wide_type'(cy_ff));

   // a limit of zero runs one test
   assign limit  = (max_iterations == '0) ? ITERATION_BITS'(1) : max_iterations;
   assign finish = escaped || (t_ff == limit);

   assign in_ready   = state_ff == ST_IDLE;
   assign out_valid  = state_ff == ST_DONE;
   assign out_last   = last_ff;
   assign out_inside = inside_ff;

   always_comb begin
      state_in  = state_ff;
      cx_in     = cx_ff;
      cy_in     = cy_ff;
      zx_in     = zx_ff;
      zy_in     = zy_ff;
      t_in      = t_ff;
      last_in   = last_ff;
      inside_in = inside_ff;
      case (state_ff)
         ST_IDLE: begin
            if (in_valid) begin
               cx_in    = in_point.cx;
               cy_in    = in_point.cy;
               zx_in    = '0;
               zy_in    = '0;
               t_in     = '0;
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            state_in = ST_ADD;
         end
         ST_ADD: begin
            if (finish) begin
               last_in   = t_ff - 1'b1;
               inside_in = !escaped;
               state_in  = ST_DONE;
            end else begin
               zx_in    = zx_new;
               zy_in    = zy_new;
               t_in     = t_ff + 1'b1;
               state_in = ST_MUL;
            end
         end
         ST_DONE: begin
            if (out_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         t_ff     <= '0;
      end else begin
         state_ff <= state_in;
         t_ff     <= t_in;
      end
   end

   always_ff @(posedge clock) begin
      cx_ff     <= cx_in;
      cy_ff     <= cy_in;
      zx_ff     <= zx_in;
      zy_ff     <= zy_in;
      last_ff   <= last_in;
      inside_ff <= inside_in;
      if (state_ff == ST_MUL) begin
         sqx_ff <= sqx_in;
         sqy_ff <= sqy_in;
         xy_ff  <= xy_in;
      end
   end

   a_mul_then_add: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_MUL |=> state_ff == ST_ADD)
      else $error("escape core: multiply step not followed by add step");

   a_add_exit: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_ADD |=> (state_ff == ST_MUL || state_ff == ST_DONE))
      else $error("escape core: add step left to a wrong state");

   a_result_held: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE && !out_ready) |=>
      (state_ff == ST_DONE && $stable(last_ff) && $stable(inside_ff)))
      else $error("escape core: stalled result changed");

   a_test_zero_ran: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DONE |-> t_ff != '0)
      else $error("escape core: result without any test run");

endmodule

/* rtl/core/mep_colour.sv */
// Colour stage and result register: col = min(255, last*scale >> 16).
// Holds the result word until popped; depends on mep_pkg.
module mep_colour
   import mep_pkg::*;
#(
   parameter int ITERATION_BITS = ITERATION_BITS_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      in_valid,
   input  logic [ITERATION_BITS-1:0] in_last,
   input  logic                      in_inside,
   output logic                      in_ready,
   input  logic [SCALE_BITS-1:0]     color_scale,
   output logic                      out_valid,
   output logic [ITERATION_BITS-1:0] out_last,
   output logic                      out_inside,
   output logic [COLOUR_BITS-1:0]    out_red,
   output logic [COLOUR_BITS-1:0]    out_green,
   output logic [COLOUR_BITS-2:0]    out_blue,
   input  logic                      out_ready
);

   localparam int CP_BITS = ITERATION_BITS + SCALE_BITS;
   localparam int HI_BITS = CP_BITS - COLOUR_SHIFT;

   logic                      valid_ff, valid_in;
   logic [ITERATION_BITS-1:0] last_ff;
   logic                      inside_ff;
   logic [CP_BITS-1:0]        prod_ff, prod_in;
   logic [HI_BITS-1:0]        hi;
   logic [COLOUR_BITS-1:0]    col;

   assign in_ready = !valid_ff || out_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;
   assign prod_in  = in_last * color_scale;

   assign hi  = prod_ff[CP_BITS-1:COLOUR_SHIFT];
   assign col = (hi > HI_BITS'(COLOUR_MAX)) ? COLOUR_MAX : hi[COLOUR_BITS-1:0];

   assign out_valid  = valid_ff;
   assign out_last   = last_ff;
   assign out_inside = inside_ff;
   assign out_red    = col;
   assign out_green  = COLOUR_MAX - col;
   assign out_blue   = col[COLOUR_BITS-1:1];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         last_ff   <= in_last;
         inside_ff <= in_inside;
         prod_ff   <= prod_in;
      end
   end

endmodule

/* test/tb_mandelbrot_escape_pixel.sv */
`timescale 1ns / 1ps
// Self-checking testbench for mandelbrot_escape_pixel: register loads with readback,
// a directed pixel table, then randomised pixels under several idle patterns.
// Depends on mep_pkg and the mandelbrot_escape_pixel RTL only.
module tb_mandelbrot_escape_pixel;
   import mep_pkg::*;

   localparam int PB = PIXEL_BITS_DEFAULT;
   localparam int IB = ITERATION_BITS_DEFAULT;
   localparam longint WORD_HI = (64'sd1 <<< (WORD_BITS - 1)) - 1;
   localparam longint WORD_LO = -WORD_HI - 1;
   localparam longint FOUR_Q  = 64'sd4 <<< FRACTION_BITS;
   localparam int SCALE_TOP   = 16711680;
   localparam int PHASES      = 8;
   localparam int PHASE_ITEMS = 60;

   typedef struct {
      logic [IB-1:0]           max_iter;
      logic [STEP_BITS-1:0]    step_x;
      logic [STEP_BITS-1:0]    step_y;
      logic signed [OFFSET_BITS-1:0] x_off;
      logic signed [OFFSET_BITS-1:0] y_off;
      logic [SCALE_BITS-1:0]   scale;
   } engine_cfg_type;

   typedef struct {
      logic [IB-1:0]          last_test;
      logic                   inside_set;
      logic [COLOUR_BITS-1:0] red;
      logic [COLOUR_BITS-1:0] green;
      logic [COLOUR_BITS-2:0] blue;
   } escape_result_type;

   typedef struct {
      int                setting;
      int                px;
      int                py;
      bit                known;
      escape_result_type want;
   } pixel_row_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   push = 1'b0;
   logic signed [PB-1:0]   req_pixel_x = '0;
   logic signed [PB-1:0]   req_pixel_y = '0;
   logic                   pop = 1'b0;
   logic                   psel = 1'b0;
   logic                   penable = 1'b0;
   logic                   pwrite = 1'b0;
   logic [CSR_ADDR_BITS-1:0] paddr = '0;
   logic [CSR_DATA_BITS-1:0] pwdata = '0;
   wire                    full;
   wire                    empty;
   wire [IB-1:0]           rsp_last_test;
   wire                    rsp_inside_set;
   wire [COLOUR_BITS-1:0]  rsp_red;
   wire [COLOUR_BITS-1:0]  rsp_green;
   wire [COLOUR_BITS-2:0]  rsp_blue;
   wire [CSR_DATA_BITS-1:0] prdata;
   wire                    pready;

   logic [CSR_INDEX_BITS-1:0] reg_order [6] = '{REG_MAX_ITERATIONS, REG_STEP_X, REG_STEP_Y,
                                                 REG_X_OFFSET, REG_Y_OFFSET, REG_COLOR_SCALE};

   engine_cfg_type    active_cfg;
   engine_cfg_type    directed_cfg [4];
   pixel_row_type     pixel_table [$];
   escape_result_type awaited_pixels [$];
   int send_idle_pct   = 0;
   int take_stall_pct  = 0;
   int mismatches      = 0;
   int results_seen    = 0;
   int inside_seen     = 0;
   int settings_loaded = 0;

   mandelbrot_escape_pixel dut (
      .clock(clock), .reset(reset),
      .push(push), .full(full), .req_pixel_x(req_pixel_x), .req_pixel_y(req_pixel_y),
      .empty(empty), .pop(pop), .rsp_last_test(rsp_last_test),
      .rsp_inside_set(rsp_inside_set), .rsp_red(rsp_red), .rsp_green(rsp_green),
      .rsp_blue(rsp_blue),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
      .prdata(prdata), .pready(pready)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   initial begin
      #(40_000_000);
      $display("tb_mandelbrot_escape_pixel: errors");
      $finish;
   end

   task automatic report_mismatch(input string field, input longint got, input longint want);
      mismatches++;
      $display("mismatch %s: got %0d want %0d (word %0d)", field, got, want, results_seen);
   endtask

   // ---------------- escape-time prediction ----------------

   function automatic longint clamp_word(input longint v);
      if (v > WORD_HI) return WORD_HI;
      if (v < WORD_LO) return WORD_LO;
      return v;
   endfunction

   // magnitude product, truncated toward zero, then signed
   function automatic longint fixed_mul(input longint a, input longint b);
      longint unsigned ma, mb, p;
      ma = (a < 0) ? -a : a;
      mb = (b < 0) ? -b : b;
      p  = (ma * mb) >> FRACTION_BITS;
      return ((a < 0) != (b < 0)) ? -longint'(p) : longint'(p);
   endfunction

   function automatic escape_result_type escape_pixel(input logic signed [PB-1:0] px,
                                                      input logic signed [PB-1:0] py);
      longint cx, cy, zx, zy, mag, re, im, col;
      int limit, last;
      escape_result_type r;
      cx = clamp_word(clamp_word(longint'(px) * longint'(active_cfg.step_x))
                      + longint'(active_cfg.x_off));
      cy = clamp_word(clamp_word(longint'(py) * longint'(active_cfg.step_y))
                      + longint'(active_cfg.y_off));
      zx = 0;
      zy = 0;
      mag = 0;
      last = 0;
      limit = (active_cfg.max_iter == 0) ? 1 : int'(active_cfg.max_iter);
      for (int t = 0; t < limit; t++) begin
         if (mag >= FOUR_Q) break;
         re   = fixed_mul(zx, zx) - fixed_mul(zy, zy);
         im   = clamp_word(2 * fixed_mul(zx, zy));
         zx   = clamp_word(re + cx);
         zy   = clamp_word(im + cy);
         mag  = fixed_mul(zx, zx) + fixed_mul(zy, zy);
         last = t;
      end
      col = (longint'(last) * longint'(active_cfg.scale)) >> COLOUR_SHIFT;
      if (col > 255) col = 255;
      r.last_test  = last[IB-1:0];
      r.inside_set = (mag < FOUR_Q);
      r.red        = col[7:0];
      r.green      = COLOUR_MAX - col[7:0];
      r.blue       = col[7:1];
      return r;
   endfunction

   // ---------------- register port ----------------

   function automatic logic [31:0] reg_image(input engine_cfg_type s,
                                             input logic [CSR_INDEX_BITS-1:0] idx);
      case (idx)
         REG_MAX_ITERATIONS: return 32'(s.max_iter);
         REG_STEP_X:         return 32'(s.step_x);
         REG_STEP_Y:         return 32'(s.step_y);
         REG_X_OFFSET:       return s.x_off;
         REG_Y_OFFSET:       return s.y_off;
         default:            return 32'(s.scale);
      endcase
   endfunction

   function automatic logic [31:0] reg_mask(input logic [CSR_INDEX_BITS-1:0] idx);
      case (idx)
         REG_MAX_ITERATIONS: return (32'd1 << IB) - 1;
         REG_STEP_X,
         REG_STEP_Y:         return (32'd1 << STEP_BITS) - 1;
         REG_COLOR_SCALE:    return (32'd1 << SCALE_BITS) - 1;
         default:            return 32'hFFFF_FFFF;
      endcase
   endfunction

   task automatic csr_write(input logic [CSR_INDEX_BITS-1:0] idx, input logic [31:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic csr_read(input logic [CSR_INDEX_BITS-1:0] idx, output logic [31:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      paddr   <= {idx, 2'b00};
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      value   = prdata;
      psel    <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic check_registers();
      logic [31:0] got;
      foreach (reg_order[i]) begin
         csr_read(reg_order[i], got);
         if ((got & reg_mask(reg_order[i])) !=
             (reg_image(active_cfg, reg_order[i]) & reg_mask(reg_order[i])))
            report_mismatch("register readback", got, reg_image(active_cfg, reg_order[i]));
      end
   endtask

   // only called with the engine idle
   task automatic load_settings(input engine_cfg_type s);
      foreach (reg_order[i]) csr_write(reg_order[i], reg_image(s, reg_order[i]));
      active_cfg = s;
      settings_loaded++;
      check_registers();
   endtask

   function automatic engine_cfg_type random_settings(input int phase);
      engine_cfg_type s;
      s.max_iter = IB'($urandom_range(2, 100));
      s.step_x   = STEP_BITS'($urandom_range(1 << 17, 1 << 21));
      s.step_y   = STEP_BITS'($urandom_range(1 << 17, 1 << 21));
      s.x_off    = OFFSET_BITS'(int'($urandom_range(0, 1 << 30)) - (1 << 29));
      s.y_off    = OFFSET_BITS'(int'($urandom_range(0, 1 << 30)) - (1 << 29));
      s.scale    = SCALE_BITS'($urandom_range(0, 1) ? (255 * 65536) / int'(s.max_iter)
                                                    : int'($urandom_range(0, SCALE_TOP)));
      case (phase)
         0: s.max_iter = IB'(1023);
         1: begin
            s.max_iter = IB'(1);
            s.step_x   = '0;
            s.step_y   = '0;
         end
         2: begin
            s.step_x = {STEP_BITS{1'b1}};
            s.step_y = '0;
            s.x_off  = 32'h8000_0000;
            s.y_off  = 32'h7FFF_FFFF;
         end
         3: s.scale = SCALE_BITS'(SCALE_TOP);
         4: s.scale = '0;
         default: ;
      endcase
      return s;
   endfunction

   // ---------------- pixel channel ----------------

   task automatic send_pixel(input logic signed [PB-1:0] px, input logic signed [PB-1:0] py,
                             input bit known, input escape_result_type want);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         push <= 1'b0;
         @(posedge clock);
      end
      push        <= 1'b1;
      req_pixel_x <= px;
      req_pixel_y <= py;
      do @(posedge clock); while (full);
      awaited_pixels.push_back(known ? want : escape_pixel(px, py));
   endtask

   // lower push, then hold off until every awaited word is back
   task automatic drain_pixels();
      push <= 1'b0;
      @(posedge clock);
      while (awaited_pixels.size() != 0) @(posedge clock);
   endtask

   function automatic logic signed [PB-1:0] random_pixel();
      if ($urandom_range(0, 1)) return PB'($urandom_range(0, (1 << PB) - 1));
      return PB'(int'($urandom_range(0, 800)) - 400);
   endfunction

   task automatic add_row(input int setting, input int px, input int py, input bit known,
                          input int last, input bit in_set, input int red, input int green,
                          input int blue);
      pixel_row_type row;
      row.setting         = setting;
      row.px              = px;
      row.py              = py;
      row.known           = known;
      row.want.last_test  = IB'(last);
      row.want.inside_set = in_set;
      row.want.red        = COLOUR_BITS'(red);
      row.want.green      = COLOUR_BITS'(green);
      row.want.blue       = (COLOUR_BITS - 1)'(blue);
      pixel_table.push_back(row);
   endtask

   task automatic check_result();
      escape_result_type want;
      if (awaited_pixels.size() == 0) begin
         report_mismatch("word with none awaited, last_test", rsp_last_test, 0);
      end else begin
         want = awaited_pixels.pop_front();
         if (rsp_last_test !== want.last_test)
            report_mismatch("last_test", rsp_last_test, want.last_test);
         if (rsp_inside_set !== want.inside_set)
            report_mismatch("inside_set", rsp_inside_set, want.inside_set);
         if (rsp_red !== want.red)     report_mismatch("red", rsp_red, want.red);
         if (rsp_green !== want.green) report_mismatch("green", rsp_green, want.green);
         if (rsp_blue !== want.blue)   report_mismatch("blue", rsp_blue, want.blue);
      end
      results_seen++;
      if (rsp_inside_set === 1'b1) inside_seen++;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         pop <= 1'b0;
      end else begin
         if (pop && !empty) check_result();
         pop <= ($urandom_range(0, 99) >= take_stall_pct);
      end
   end

   // ---------------- run ----------------

   initial begin
      int current;
      directed_cfg[0] = '{IB'(MAX_ITERATIONS_RESET), STEP_X_RESET, STEP_Y_RESET, '0, '0,
                          COLOR_SCALE_RESET};
      // zero iteration limit behaves as one
      directed_cfg[1] = '{'0, STEP_X_RESET, STEP_Y_RESET, '0, '0, SCALE_BITS'(SCALE_TOP)};
      directed_cfg[2] = '{IB'(1023), STEP_X_RESET, STEP_Y_RESET, '0, '0,
                          SCALE_BITS'(SCALE_TOP)};
      directed_cfg[3] = '{IB'(1), {STEP_BITS{1'b1}}, '0, 32'h7FFF_FFFF, 32'h8000_0000, '0};
      active_cfg = directed_cfg[0];

      // setting, px, py, known, last_test, inside, red, green, blue
      add_row(0,     0,     0, 1, 49, 1, 249,   6, 124);
      add_row(0, -2048, -2048, 1,  0, 0,   0, 255,   0);
      add_row(0,  2047,  2047, 1,  0, 0,   0, 255,   0);
      add_row(0, -2048,  2047, 1,  0, 0,   0, 255,   0);
      add_row(0,  2047, -2048, 1,  0, 0,   0, 255,   0);
      add_row(0,     1,    -1, 0,  0, 0,   0,   0,   0);
      add_row(0,    -1,     1, 0,  0, 0,   0,   0,   0);
      add_row(0,     0,     1, 0,  0, 0,   0,   0,   0);
      add_row(0,  -192,     0, 0,  0, 0,   0,   0,   0);
      add_row(0,  -512,     0, 0,  0, 0,   0,   0,   0);
      add_row(0,    64,     0, 0,  0, 0,   0,   0,   0);
      add_row(0,  -100,   170, 0,  0, 0,   0,   0,   0);
      add_row(0,    32,   100, 0,  0, 0,   0,   0,   0);
      add_row(0,  -440,     0, 0,  0, 0,   0,   0,   0);
      add_row(1,     0,     0, 1,  0, 1,   0, 255,   0);
      add_row(1, -2048, -2048, 1,  0, 0,   0, 255,   0);
      add_row(1,   100,   -50, 0,  0, 0,   0,   0,   0);
      // colour saturates at full scale
      add_row(2,     0,     0, 1, 1022, 1, 255, 0, 127);
      add_row(2,  -192,     0, 0,  0, 0,   0,   0,   0);
      add_row(2,    90,   120, 0,  0, 0,   0,   0,   0);
      add_row(3,     1,     1, 0,  0, 0,   0,   0,   0);
      add_row(3,    -1,    -1, 0,  0, 0,   0,   0,   0);
      add_row(3,     0,     0, 0,  0, 0,   0,   0,   0);
      add_row(3, -2048,  2047, 0,  0, 0,   0,   0,   0);

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      check_registers();

      current = 0;
      foreach (pixel_table[i]) begin
         if (pixel_table[i].setting != current) begin
            drain_pixels();
            current = pixel_table[i].setting;
            load_settings(directed_cfg[current]);
         end
         send_pixel(PB'(pixel_table[i].px), PB'(pixel_table[i].py), pixel_table[i].known,
                    pixel_table[i].want);
      end
      drain_pixels();

      for (int phase = 0; phase < PHASES; phase++) begin
         case (phase % 4)
            0: begin send_idle_pct = 0;  take_stall_pct = 0;  end
            1: begin send_idle_pct = 54; take_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  take_stall_pct = 54; end
            default: begin send_idle_pct = 9; take_stall_pct = 9; end
         endcase
         load_settings(random_settings(phase));
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            // sender holds off mid-phase until the engine has emptied
            if (phase == 5 && n == PHASE_ITEMS / 2) drain_pixels();
            send_pixel(random_pixel(), random_pixel(), 1'b0, '{default: '0});
         end
         drain_pixels();
      end

      repeat (20) @(posedge clock);
      $display("%0d pixel words checked under %0d register settings, %0d inside the set",
               results_seen, settings_loaded, inside_seen);
      $display("idle patterns: none, sender, receiver, both; %0d mismatches", mismatches);
      if (mismatches == 0) begin
         $display("tb_mandelbrot_escape_pixel: clean");
      end else begin
         $display("tb_mandelbrot_escape_pixel: errors");
      end
      $finish;
   end

endmodule

/* mandelbrot_escape_pixel.f */
rtl/core/mep_pkg.sv
rtl/core/mep_front.sv
rtl/core/mep_queue.sv
rtl/core/mep_escape.sv
rtl/core/mep_colour.sv
rtl/core/mandelbrot_escape_pixel.sv
test/tb_mandelbrot_escape_pixel.sv
